>>> hw/rtl/sdkf_pkg.sv
// Shared types, constants and the scancode-to-ASCII table for the key decoder.
package sdkf_pkg;

  localparam int unsigned CODE_W     = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  // Scancode set 1 markers
  localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
  localparam logic [7:0] SC_ARROW_UP    = 8'h48;
  localparam logic [7:0] SC_ARROW_DOWN  = 8'h50;
  localparam logic [7:0] SC_ARROW_LEFT  = 8'h4B;
  localparam logic [7:0] SC_ARROW_RIGHT = 8'h4D;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARROW_UP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARROW_DOWN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARROW_LEFT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARROW_RIGHT = 2'd3;

  localparam logic [CODE_W-1:0] ARROW_UP_RESET    = 8'd128;
  localparam logic [CODE_W-1:0] ARROW_DOWN_RESET  = 8'd129;
  localparam logic [CODE_W-1:0] ARROW_LEFT_RESET  = 8'd130;
  localparam logic [CODE_W-1:0] ARROW_RIGHT_RESET = 8'd131;

  typedef struct packed {
    logic [CODE_W-1:0] up;
    logic [CODE_W-1:0] down;
    logic [CODE_W-1:0] left;
    logic [CODE_W-1:0] right;
  } arrow_cfg_t;

  // Command from the pipeline control to the ring for one transaction
  typedef struct packed {
    logic              load;
    logic              pop;
    logic [CODE_W-1:0] code;
  } ring_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] queued_count;
    logic               dropped_full;
    logic [CODE_W-1:0]  key_value;
    logic               key_valid;
  } ring_res_t;

  // Make codes without a prefix; anything not listed maps to zero.
  function automatic logic [CODE_W-1:0] ascii_lookup(input logic [6:0] sc);
    logic [CODE_W-1:0] c;
    c = '0;
    case (sc)
      7'd1:    c = 8'h1B;
      7'd2:    c = 8'h31;
      7'd3:    c = 8'h32;
      7'd4:    c = 8'h33;
      7'd5:    c = 8'h34;
      7'd6:    c = 8'h35;
      7'd7:    c = 8'h36;
      7'd8:    c = 8'h37;
      7'd9:    c = 8'h38;
      7'd10:   c = 8'h39;
      7'd11:   c = 8'h30;
      7'd12:   c = 8'h2D;
      7'd13:   c = 8'h3D;
      7'd14:   c = 8'h08;
      7'd15:   c = 8'h09;
      7'd16:   c = 8'h71;
      7'd17:   c = 8'h77;
      7'd18:   c = 8'h65;
      7'd19:   c = 8'h72;
      7'd20:   c = 8'h74;
      7'd21:   c = 8'h79;
      7'd22:   c = 8'h75;
      7'd23:   c = 8'h69;
      7'd24:   c = 8'h6F;
      7'd25:   c = 8'h70;
      7'd26:   c = 8'h5B;
      7'd27:   c = 8'h5D;
      7'd28:   c = 8'h0A;
      7'd30:   c = 8'h61;
      7'd31:   c = 8'h73;
      7'd32:   c = 8'h64;
      7'd33:   c = 8'h66;
      7'd34:   c = 8'h67;
      7'd35:   c = 8'h68;
      7'd36:   c = 8'h6A;
      7'd37:   c = 8'h6B;
      7'd38:   c = 8'h6C;
      7'd39:   c = 8'h3B;
      7'd40:   c = 8'h27;
      7'd41:   c = 8'h60;
      7'd43:   c = 8'h5C;
      7'd44:   c = 8'h7A;
      7'd45:   c = 8'h78;
      7'd46:   c = 8'h63;
      7'd47:   c = 8'h76;
      7'd48:   c = 8'h62;
      7'd49:   c = 8'h6E;
      7'd50:   c = 8'h6D;
      7'd51:   c = 8'h2C;
      7'd52:   c = 8'h2E;
      7'd53:   c = 8'h2F;
      7'd55:   c = 8'h2A;
      7'd57:   c = 8'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/sdkf_decode.sv
// Scancode decoder: extended-prefix tracking, arrow mapping and table lookup.
module sdkf_decode
  import sdkf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CODE_W-1:0] scan_byte,
  input  arrow_cfg_t        arrows,
  output logic [CODE_W-1:0] code
);

  logic prefix;
  logic prefix_next;

  always_comb begin
    code        = '0;
    prefix_next = prefix;
    if (scan_byte == SC_EXT_PREFIX) begin
      prefix_next = 1'b1;
    end else if (scan_byte[7]) begin
      // Break code: key released, nothing to queue.
      prefix_next = 1'b0;
    end else if (prefix) begin
      prefix_next = 1'b0;
      unique case (scan_byte)
        SC_ARROW_UP:    code = arrows.up;
        SC_ARROW_DOWN:  code = arrows.down;
        SC_ARROW_LEFT:  code = arrows.left;
        SC_ARROW_RIGHT: code = arrows.right;
        default:        code = '0;
      endcase
    end else begin
      code = ascii_lookup(scan_byte[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
    end else if (step) begin
      prefix <= prefix_next;
    end
  end

endmodule

>>> hw/rtl/sdkf_ring.sv
// Key ring: circular buffer with its pointers, fill count and result register.
module sdkf_ring
  import sdkf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  ring_cmd_t cmd,
  output ring_res_t res
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = (PW > COUNT_W) ? PW : COUNT_W;
  localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

  logic [CODE_W-1:0] ring [RING_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     count;
  logic [PW-1:0]     count_next;
  logic [CW-1:0]     count_wide;
  logic              empty;
  logic              full;
  logic              do_pop;
  logic              do_push;
  logic              drop;

  assign empty = (count == '0);
  assign full  = (count == LAST);

  always_comb begin
    do_pop     = cmd.load && cmd.pop && !empty;
    do_push    = cmd.load && !cmd.pop && (cmd.code != '0) && !full;
    drop       = !cmd.pop && (cmd.code != '0) && full;
    count_next = count;
    if (do_pop) begin
      count_next = count - 1'b1;
    end else if (do_push) begin
      count_next = count + 1'b1;
    end
    count_wide = CW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ring[wr_ptr] <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // The memory read lands directly in the result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res.key_valid    <= do_pop;
      res.key_value    <= do_pop ? ring[rd_ptr] : '0;
      res.dropped_full <= drop;
      res.queued_count <= count_wide[COUNT_W-1:0];
    end
  end

endmodule

>>> hw/rtl/scancode_decoder_key_fifo.sv
// Top level of the scancode decoder with its key ring.
// One transaction on the slave side is taken every cycle and yields exactly one
// result transaction, presented on the master side: the input register holds it,
// then the decode, the ring update and the ring read all happen on the way into the
// result register. The only stall comes from the master side: while a result waits
// and m_tready is low, the input register holds and s_tready drops once it is full.
// The ring needs no clearing after reset. The user must set the arrow key codes
// through the configuration port only while the block is idle; the block does not enforce this.
module scancode_decoder_key_fifo
  import sdkf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CODE_W-1:0]     s_tdata,   // [7:0] scan_byte
  input  logic                  s_tuser,   // [0] func (1 = pop)
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] key_valid, [8:1] key_value,
                                           // [9] dropped_full, [13:10] queued_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CODE_W-1:0]     cfg_data
);

  arrow_cfg_t        arrows;
  logic              in_valid;
  logic              in_func;
  logic [CODE_W-1:0] in_byte;
  logic              advance;
  logic              accept;
  logic [CODE_W-1:0] code;
  ring_cmd_t         cmd;
  ring_res_t         res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrows.up    <= ARROW_UP_RESET;
      arrows.down  <= ARROW_DOWN_RESET;
      arrows.left  <= ARROW_LEFT_RESET;
      arrows.right <= ARROW_RIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ARROW_UP:    arrows.up    <= cfg_data;
        REG_ARROW_DOWN:  arrows.down  <= cfg_data;
        REG_ARROW_LEFT:  arrows.left  <= cfg_data;
        REG_ARROW_RIGHT: arrows.right <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_func <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  sdkf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (advance && !in_func),
    .scan_byte (in_byte),
    .arrows    (arrows),
    .code      (code)
  );

  assign cmd.load = advance;
  assign cmd.pop  = in_func;
  assign cmd.code = code;

  sdkf_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  assign m_tdata = {2'b00, res.queued_count, res.dropped_full, res.key_value, res.key_valid};

endmodule

>>> hw/rtl/sdkf_checker.sv
// Port-level checks on the result stream of the scancode decoder, bound to the top level.
module sdkf_checker
  import sdkf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'((RING_DEPTH - 1) % 16);

  // A popped key and a dropped key never come from the same transaction.
  a_pop_not_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
    else $error("key_valid and dropped_full both set");

  // A key value is only shown when a key was actually popped.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == '0))
    else $error("key_value nonzero without key_valid");

  // A drop happens only when the ring was full, and it stays full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> (m_tdata[13:10] == FULL_COUNT))
    else $error("dropped_full with ring not full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind scancode_decoder_key_fifo sdkf_checker #(.RING_DEPTH(RING_DEPTH)) u_sdkf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb_scancode_decoder_key_fifo.sv
// Self-checking testbench for the scancode decoder and its key ring.
`timescale 1ns / 1ps

module tb_scancode_decoder_key_fifo;
  import sdkf_pkg::*;

  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_POP    = 1'b1;
  localparam int   RING_SLOTS  = 15;
  localparam int   TABLE_SIZE  = 58;
  localparam int   CYCLE_LIMIT = 200000;
  localparam logic [7:0] SC_RELEASE_BIT = 8'h80;

  // Set 1 make codes 0x00 to 0x39; everything above maps to no key.
  localparam logic [7:0] SET1_ASCII [0:TABLE_SIZE-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  typedef struct packed {
    logic       func;
    logic [7:0] scan_byte;
  } scan_item_t;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_value;
    logic       dropped_full;
    logic [3:0] queued_count;
  } key_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CODE_W-1:0]     s_tdata = '0;   // [7:0] scan_byte
  logic                  s_tuser = 1'b0; // [0] func (1 = pop)
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [0] key_valid, [8:1] key_value,
                                         // [9] dropped_full, [13:10] queued_count
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CODE_W-1:0]     cfg_data = '0;

  scan_item_t  pending_scans[$];
  key_result_t expected_keys[$];
  logic [7:0]  queued_keys[$];
  arrow_cfg_t  arrow_codes;
  logic        prefix_armed;
  scan_item_t  next_scan;
  bit          idling_on = 1'b1;
  int          scans_queued = 0;
  int          fail_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          cycle_count = 0;

  scancode_decoder_key_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Works out the result of one accepted transaction and updates the shadow state.
  task automatic predict_key(input logic func, input logic [7:0] sc);
    key_result_t res;
    logic [7:0]  code;
    res  = '0;
    code = 8'h00;
    if (func == FUNC_POP) begin
      if (queued_keys.size() != 0) begin
        res.key_valid = 1'b1;
        res.key_value = queued_keys.pop_front();
      end
    end else begin
      if (sc == SC_EXT_PREFIX) begin
        prefix_armed = 1'b1;
      end else if ((sc & SC_RELEASE_BIT) != 0) begin
        prefix_armed = 1'b0;
      end else if (prefix_armed) begin
        prefix_armed = 1'b0;
        case (sc)
          SC_ARROW_UP:    code = arrow_codes.up;
          SC_ARROW_DOWN:  code = arrow_codes.down;
          SC_ARROW_LEFT:  code = arrow_codes.left;
          SC_ARROW_RIGHT: code = arrow_codes.right;
          default:        code = 8'h00;
        endcase
      end else if (sc < TABLE_SIZE) begin
        code = SET1_ASCII[sc[5:0]];
      end
      if (code != 8'h00) begin
        if (queued_keys.size() < RING_SLOTS) queued_keys.push_back(code);
        else res.dropped_full = 1'b1;
      end
    end
    res.queued_count = 4'(queued_keys.size());
    expected_keys.push_back(res);
  endtask

  task automatic check_key(input logic [OUT_DATA_W-1:0] d);
    key_result_t want;
    if (expected_keys.size() == 0) begin
      $error("result %h arrived with no transaction outstanding", d);
      fail_count++;
    end else begin
      want = expected_keys.pop_front();
      if (d[0] !== want.key_valid) begin
        $error("key_valid: expected %0d, actual %0d", want.key_valid, d[0]);
        fail_count++;
      end
      if (d[8:1] !== want.key_value) begin
        $error("key_value: expected %0d, actual %0d", want.key_value, d[8:1]);
        fail_count++;
      end
      if (d[9] !== want.dropped_full) begin
        $error("dropped_full: expected %0d, actual %0d", want.dropped_full, d[9]);
        fail_count++;
      end
      if (d[13:10] !== want.queued_count) begin
        $error("queued_count: expected %0d, actual %0d", want.queued_count, d[13:10]);
        fail_count++;
      end
    end
  endtask

  // Source side: holds a transaction until it is taken, with random gaps between.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_key(s_tuser, s_tdata);
      if (s_tvalid && !s_tready) begin
        // keep the current transaction on the bus
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 8);
        s_tvalid <= 1'b0;
      end else if (pending_scans.size() != 0) begin
        next_scan = pending_scans.pop_front();
        s_tvalid  <= 1'b1;
        s_tuser   <= next_scan.func;
        s_tdata   <= next_scan.scan_byte;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: checks each result and stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) check_key(m_tdata);
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic add_scan(input logic func, input logic [7:0] sc);
    scan_item_t it;
    it.func      = func;
    it.scan_byte = sc;
    pending_scans.push_back(it);
    scans_queued++;
  endtask

  function automatic logic [7:0] pick_arrow();
    logic [7:0] sc;
    case ($urandom_range(0, 3))
      0:       sc = SC_ARROW_UP;
      1:       sc = SC_ARROW_DOWN;
      2:       sc = SC_ARROW_LEFT;
      default: sc = SC_ARROW_RIGHT;
    endcase
    return sc;
  endfunction

  // Mostly realistic keyboard traffic, with bursts long enough to fill the ring.
  task automatic add_traffic(input int count);
    int         goal;
    int         kind;
    logic [7:0] sc;
    goal = scans_queued + count;
    while (scans_queued < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 8)) begin
          sc = 8'($urandom_range(0, TABLE_SIZE - 1));
          add_scan(FUNC_DECODE, sc);
          if ($urandom_range(0, 1) == 1) add_scan(FUNC_DECODE, sc | SC_RELEASE_BIT);
        end
      end else if (kind < 50) begin
        sc = pick_arrow();
        add_scan(FUNC_DECODE, SC_EXT_PREFIX);
        add_scan(FUNC_DECODE, sc);
        add_scan(FUNC_DECODE, SC_EXT_PREFIX);
        add_scan(FUNC_DECODE, sc | SC_RELEASE_BIT);
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 20)) add_scan(FUNC_POP, 8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        repeat ($urandom_range(16, 20)) add_scan(FUNC_DECODE, 8'($urandom_range(1, 57)));
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 6))
          add_scan(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        add_scan(FUNC_DECODE, SC_EXT_PREFIX);
        if ($urandom_range(0, 1) == 1) add_scan(FUNC_DECODE, SC_EXT_PREFIX);
        add_scan(FUNC_DECODE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // The source pauses here until every result of the phase has been checked.
  task automatic wait_drained();
    while (pending_scans.size() != 0 || s_tvalid || expected_keys.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_arrows(input logic [7:0] up, input logic [7:0] down,
                              input logic [7:0] left, input logic [7:0] right);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ARROW_UP;
    cfg_data  <= up;
    @(posedge clk);
    cfg_index <= REG_ARROW_DOWN;
    cfg_data  <= down;
    @(posedge clk);
    cfg_index <= REG_ARROW_LEFT;
    cfg_data  <= left;
    @(posedge clk);
    cfg_index <= REG_ARROW_RIGHT;
    cfg_data  <= right;
    @(posedge clk);
    cfg_we    <= 1'b0;
    arrow_codes.up    = up;
    arrow_codes.down  = down;
    arrow_codes.left  = left;
    arrow_codes.right = right;
  endtask

  initial begin
    arrow_codes.up    = ARROW_UP_RESET;
    arrow_codes.down  = ARROW_DOWN_RESET;
    arrow_codes.left  = ARROW_LEFT_RESET;
    arrow_codes.right = ARROW_RIGHT_RESET;
    prefix_armed      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed start with the reset arrow codes: empty pop, table edges,
    // repeated prefix, every arrow, prefixed non-arrow and a release after a prefix.
    add_scan(FUNC_POP, 8'hFF);
    add_scan(FUNC_DECODE, 8'h00);
    add_scan(FUNC_DECODE, 8'h7F);
    add_scan(FUNC_DECODE, 8'h1E);
    add_scan(FUNC_DECODE, 8'h39);
    add_scan(FUNC_DECODE, 8'h01);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, SC_ARROW_UP);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, SC_ARROW_DOWN);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, SC_ARROW_LEFT);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, SC_ARROW_RIGHT);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, 8'h1E);
    add_scan(FUNC_DECODE, SC_EXT_PREFIX);
    add_scan(FUNC_DECODE, 8'h9E);
    add_scan(FUNC_DECODE, 8'h1E);
    add_scan(FUNC_DECODE, 8'hFF);
    add_scan(FUNC_DECODE, SC_RELEASE_BIT);
    add_scan(FUNC_POP, 8'h00);
    add_scan(FUNC_POP, 8'hAA);
    add_scan(FUNC_POP, 8'h55);
    add_traffic(150);

    write_arrows(8'd1, 8'd255, 8'd1, 8'd255);
    add_traffic(130);

    write_arrows(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    add_traffic(110);

    // Final stretch runs at full rate on both sides.
    write_arrows(8'd255, 8'd1, 8'd255, 8'd1);
    idling_on = 1'b0;
    add_traffic(110);

    wait_drained();
    repeat (10) @(negedge clk);
    if (expected_keys.size() != 0) begin
      $error("%0d results never arrived", expected_keys.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sdkf_pkg.sv
hw/rtl/sdkf_decode.sv
hw/rtl/sdkf_ring.sv
hw/rtl/scancode_decoder_key_fifo.sv
hw/rtl/sdkf_checker.sv
test/tb_scancode_decoder_key_fifo.sv
